// ----- rtl/core/mgsqr_pkg.sv -----
// ----------------------------------------------------------------------------
// mgsqr_pkg
// Shared types, codes and fixed-point helpers of the Gram-Schmidt QR block.
// ----------------------------------------------------------------------------
`default_nettype none

package mgsqr_pkg;

    localparam int CFG_DATA_W = 4;

    typedef enum logic [0:0] {
        CFG_VECTOR_LENGTH = 1'b0,
        CFG_VECTOR_COUNT  = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD_IN,
        OP_FLAG_CLR,
        OP_READ,
        OP_ACC_CLR,
        OP_MUL,
        OP_ACC_DOT,
        OP_ACC_SQ,
        OP_R_WR_OFF,
        OP_MUL_UPD,
        OP_WR_UPD,
        OP_SQRT_START,
        OP_R_WR_DIAG,
        OP_DIV_START,
        OP_WR_Q,
        OP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        logic       is_r;
        logic [2:0] row;
        logic [1:0] col;
        logic       last;
        logic       zero;
    } out_meta_t;

    typedef struct packed {
        dp_op_t    op;
        out_meta_t meta;
    } dp_cmd_t;

    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
        logic s_zero;
    } dp_status_t;

    localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
    localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

    function automatic logic signed [71:0] rnd16(input logic signed [71:0] x);
        logic signed [71:0] y;
        y = x + 72'sd32768;
        return y >>> 16;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
        logic signed [31:0] y;
        if (x > SAT_HI)
        begin
            y = 32'sh7fffffff;
        end
        else if (x < SAT_LO)
        begin
            y = 32'sh80000000;
        end
        else
        begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mgsqr_ram.sv -----
// ----------------------------------------------------------------------------
// mgsqr_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mgsqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr_a,
    output logic      [WIDTH-1:0] rd_data_a,
    input  wire logic [AW-1:0]    rd_addr_b,
    output logic      [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mgsqr_datapath.sv -----
// ----------------------------------------------------------------------------
// mgsqr_datapath
// Vector and R stores, multiplier, accumulators, square root and divider
// units, and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module mgsqr_datapath #(
    parameter int MAX_LENGTH = 8,
    parameter int MAX_COUNT  = 4,
    parameter int AW  = (MAX_LENGTH * MAX_COUNT > 1) ? $clog2(MAX_LENGTH * MAX_COUNT) : 1,
    parameter int RAW = (MAX_COUNT * MAX_COUNT > 1) ? $clog2(MAX_COUNT * MAX_COUNT) : 1,
    parameter int CW  = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mgsqr_pkg::dp_cmd_t   cmd,
    input  wire logic [AW-1:0]        v_wr_addr,
    input  wire logic [AW-1:0]        v_rd_addr_a,
    input  wire logic [AW-1:0]        v_rd_addr_b,
    input  wire logic [RAW-1:0]       r_addr,
    input  wire logic [CW-1:0]        col_sel,
    input  wire logic signed [31:0]   element,
    output mgsqr_pkg::dp_status_t     status,
    output logic signed [31:0]        value,
    output logic                      is_r_entry,
    output logic [2:0]                row_index,
    output logic [1:0]                col_index,
    output logic                      degenerate,
    output logic                      last_result
);

    import mgsqr_pkg::*;

    logic [31:0]        rd_a_raw;
    logic [31:0]        rd_b_raw;
    logic [31:0]        r_rd_raw;
    logic [31:0]        r_unused;
    logic signed [31:0] rd_a;
    logic signed [31:0] rd_b;

    logic signed [63:0] prod_reg;
    logic signed [31:0] va_reg;
    logic signed [71:0] acc_reg;
    logic [63:0]        s_reg;
    logic signed [31:0] r_reg;

    logic [63:0]        sq_n_reg;
    logic [33:0]        sq_rem_reg;
    logic [31:0]        sq_root_reg;
    logic [4:0]         sq_cnt_reg;
    logic               sq_busy_reg;

    logic [47:0]        dv_d_reg;
    logic [31:0]        dv_rem_reg;
    logic [47:0]        dv_q_reg;
    logic [5:0]         dv_cnt_reg;
    logic               dv_busy_reg;
    logic               dv_neg_reg;

    logic [MAX_COUNT-1:0] flags_reg;

    logic signed [31:0] mul_x;
    logic signed [63:0] mul_res;
    logic [64:0]        s_sum;
    logic signed [31:0] upd_val;
    logic signed [31:0] r_val;
    logic [31:0]        diag_val;
    logic [35:0]        sq_sh;
    logic [35:0]        sq_trial;
    logic [32:0]        dv_sh;
    logic [31:0]        mag;
    logic [31:0]        q32;
    logic [31:0]        q_val;

    logic               v_we;
    logic [31:0]        v_wd;
    logic               r_we;
    logic [31:0]        r_wd;
    logic               rd_en;

    assign rd_a = signed'(rd_a_raw);
    assign rd_b = signed'(rd_b_raw);

    assign mul_x    = (cmd.op == OP_MUL_UPD) ? r_reg : rd_a;
    assign mul_res  = mul_x * rd_b;
    assign s_sum    = {1'b0, s_reg} + {1'b0, prod_reg};
    assign upd_val  = sat32(72'(va_reg) - rnd16(72'(prod_reg)));
    assign r_val    = sat32(rnd16(acc_reg));
    assign diag_val = status.s_zero ? 32'd0 :
                      (sq_root_reg[31] ? 32'h7fffffff : sq_root_reg);
    assign sq_sh    = {sq_rem_reg, sq_n_reg[63:62]};
    assign sq_trial = {2'b00, sq_root_reg, 2'b01};
    assign dv_sh    = {dv_rem_reg, dv_d_reg[47]};
    assign mag      = rd_a[31] ? (32'd0 - rd_a_raw) : rd_a_raw;
    assign q32      = dv_q_reg[31:0];
    assign q_val    = dv_neg_reg ? (32'd0 - q32) : q32;

    assign rd_en = (cmd.op == OP_READ);

    always_comb
    begin
        v_we = 1'b0;
        v_wd = upd_val;
        r_we = 1'b0;
        r_wd = r_val;
        case (cmd.op)
            OP_LOAD_IN:
            begin
                v_we = 1'b1;
                v_wd = element;
            end
            OP_WR_UPD:
            begin
                v_we = 1'b1;
            end
            OP_WR_Q:
            begin
                v_we = 1'b1;
                v_wd = q_val;
            end
            OP_R_WR_OFF:
            begin
                r_we = 1'b1;
            end
            OP_R_WR_DIAG:
            begin
                r_we = 1'b1;
                r_wd = diag_val;
            end
            default:
            begin
                v_we = 1'b0;
            end
        endcase
    end

    mgsqr_ram #(
        .WIDTH (32),
        .DEPTH (MAX_LENGTH * MAX_COUNT),
        .AW    (AW)
    ) u_vec_ram (
        .clk       (clk),
        .wr_en     (v_we),
        .wr_addr   (v_wr_addr),
        .wr_data   (v_wd),
        .rd_en     (rd_en),
        .rd_addr_a (v_rd_addr_a),
        .rd_data_a (rd_a_raw),
        .rd_addr_b (v_rd_addr_b),
        .rd_data_b (rd_b_raw)
    );

    mgsqr_ram #(
        .WIDTH (32),
        .DEPTH (MAX_COUNT * MAX_COUNT),
        .AW    (RAW)
    ) u_r_ram (
        .clk       (clk),
        .wr_en     (r_we),
        .wr_addr   (r_addr),
        .wr_data   (r_wd),
        .rd_en     (rd_en),
        .rd_addr_a (r_addr),
        .rd_data_a (r_rd_raw),
        .rd_addr_b (r_addr),
        .rd_data_b (r_unused)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            dv_busy_reg <= 1'b0;
            flags_reg   <= '0;
        end
        else
        begin
            if (cmd.op == OP_SQRT_START)
            begin
                sq_busy_reg <= 1'b1;
            end
            else if (sq_busy_reg && sq_cnt_reg == 5'd0)
            begin
                sq_busy_reg <= 1'b0;
            end
            if (cmd.op == OP_DIV_START)
            begin
                dv_busy_reg <= 1'b1;
            end
            else if (dv_busy_reg && dv_cnt_reg == 6'd0)
            begin
                dv_busy_reg <= 1'b0;
            end
            if (cmd.op == OP_FLAG_CLR)
            begin
                flags_reg <= '0;
            end
            else if (cmd.op == OP_R_WR_DIAG && status.s_zero)
            begin
                flags_reg[col_sel] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_busy_reg)
        begin
            sq_n_reg   <= {sq_n_reg[61:0], 2'b00};
            sq_cnt_reg <= sq_cnt_reg - 5'd1;
            if (sq_sh >= sq_trial)
            begin
                sq_rem_reg  <= 34'(sq_sh - sq_trial);
                sq_root_reg <= {sq_root_reg[30:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= sq_sh[33:0];
                sq_root_reg <= {sq_root_reg[30:0], 1'b0};
            end
        end
        if (dv_busy_reg)
        begin
            dv_d_reg   <= {dv_d_reg[46:0], 1'b0};
            dv_cnt_reg <= dv_cnt_reg - 6'd1;
            if (dv_sh >= {1'b0, sq_root_reg})
            begin
                dv_rem_reg <= 32'(dv_sh - {1'b0, sq_root_reg});
                dv_q_reg   <= {dv_q_reg[46:0], 1'b1};
            end
            else
            begin
                dv_rem_reg <= dv_sh[31:0];
                dv_q_reg   <= {dv_q_reg[46:0], 1'b0};
            end
        end
        case (cmd.op)
            OP_ACC_CLR:
            begin
                acc_reg <= '0;
                s_reg   <= '0;
            end
            OP_MUL:
            begin
                prod_reg <= mul_res;
            end
            OP_MUL_UPD:
            begin
                prod_reg <= mul_res;
                va_reg   <= rd_a;
            end
            OP_ACC_DOT:
            begin
                acc_reg <= acc_reg + 72'(prod_reg);
            end
            OP_ACC_SQ:
            begin
                s_reg <= s_sum[64] ? '1 : s_sum[63:0];
            end
            OP_R_WR_OFF:
            begin
                r_reg <= r_val;
            end
            OP_SQRT_START:
            begin
                sq_n_reg    <= s_reg;
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                sq_cnt_reg  <= 5'd31;
            end
            OP_DIV_START:
            begin
                dv_d_reg   <= {mag, 16'd0} + {17'd0, sq_root_reg[31:1]};
                dv_rem_reg <= '0;
                dv_q_reg   <= '0;
                dv_cnt_reg <= 6'd47;
                dv_neg_reg <= rd_a[31];
            end
            OP_OUT_LOAD:
            begin
                value       <= cmd.meta.zero ? 32'sd0 :
                               (cmd.meta.is_r ? signed'(r_rd_raw) : rd_a);
                is_r_entry  <= cmd.meta.is_r;
                row_index   <= cmd.meta.row;
                col_index   <= cmd.meta.col;
                last_result <= cmd.meta.last;
                degenerate  <= flags_reg[col_sel];
            end
            default:
            begin
                va_reg <= va_reg;
            end
        endcase
    end

    assign status.sqrt_busy = sq_busy_reg;
    assign status.div_busy  = dv_busy_reg;
    assign status.s_zero    = (s_reg == 64'd0);

endmodule

`default_nettype wire

// ----- rtl/core/mgsqr_ctrl.sv -----
// ----------------------------------------------------------------------------
// mgsqr_ctrl
// Sequencer: loading, Gram-Schmidt passes, normalization and output run.
// ----------------------------------------------------------------------------
`default_nettype none

module mgsqr_ctrl #(
    parameter int MAX_LENGTH = 8,
    parameter int MAX_COUNT  = 4,
    parameter int AW  = (MAX_LENGTH * MAX_COUNT > 1) ? $clog2(MAX_LENGTH * MAX_COUNT) : 1,
    parameter int RAW = (MAX_COUNT * MAX_COUNT > 1) ? $clog2(MAX_COUNT * MAX_COUNT) : 1,
    parameter int CW  = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1,
    parameter int KW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_index,
    input  wire logic [mgsqr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    input  wire mgsqr_pkg::dp_status_t        status,
    output mgsqr_pkg::dp_cmd_t                cmd,
    output logic [AW-1:0]                     v_wr_addr,
    output logic [AW-1:0]                     v_rd_addr_a,
    output logic [AW-1:0]                     v_rd_addr_b,
    output logic [RAW-1:0]                    r_addr,
    output logic [CW-1:0]                     col_sel
);

    import mgsqr_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD, S_INIT, S_VEC,
        S_DOT_BEGIN, S_DOT_RD, S_DOT_MUL, S_DOT_ACC, S_R_WR,
        S_UPD_RD, S_UPD_MUL, S_UPD_WR,
        S_NORM_BEGIN, S_SQ_RD, S_SQ_MUL, S_SQ_ACC, S_SQRT_GO, S_SQRT_WAIT,
        S_DIAG, S_Q_RD, S_DIV_GO, S_DIV_WAIT, S_Q_WR, S_VEC_END,
        S_OUT_RD, S_OUT_LD, S_OUT_HOLD
    } state_t;

    state_t      state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, vi_reg, vi_next;
    logic [KW-1:0] k_reg, k_next, ki_reg, ki_next;
    logic        phase_r_reg, phase_r_next;
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  len_cfg_reg, len_cfg_next;
    logic [2:0]  cnt_cfg_reg, cnt_cfg_next;
    logic [KW-1:0] len_last;
    logic [CW-1:0] cnt_last;
    logic        k_end, j_end, i_end;

    function automatic logic [AW-1:0] vaddr(input logic [CW-1:0] vi, input logic [KW-1:0] ki);
        return AW'(int'(vi) * MAX_LENGTH + int'(ki));
    endfunction

    function automatic logic [RAW-1:0] raddr(input logic [CW-1:0] ra, input logic [CW-1:0] cb);
        return RAW'(int'(ra) * MAX_COUNT + int'(cb));
    endfunction

    always_comb
    begin
        if (len_cfg_reg == 4'd0)
        begin
            len_last = '0;
        end
        else if (8'(len_cfg_reg) > 8'(MAX_LENGTH))
        begin
            len_last = KW'(MAX_LENGTH - 1);
        end
        else
        begin
            len_last = KW'(len_cfg_reg - 4'd1);
        end
        if (cnt_cfg_reg == 3'd0)
        begin
            cnt_last = '0;
        end
        else if (8'(cnt_cfg_reg) > 8'(MAX_COUNT))
        begin
            cnt_last = CW'(MAX_COUNT - 1);
        end
        else
        begin
            cnt_last = CW'(cnt_cfg_reg - 3'd1);
        end
    end

    assign k_end = (k_reg == len_last);
    assign j_end = (j_reg == cnt_last);
    assign i_end = (i_reg == cnt_last);

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        vi_next        = vi_reg;
        ki_next        = ki_reg;
        phase_r_next   = phase_r_reg;
        out_valid_next = out_valid_reg;
        len_cfg_next   = len_cfg_reg;
        cnt_cfg_next   = cnt_cfg_reg;
        cmd.op         = OP_IDLE;
        cmd.meta.is_r  = phase_r_reg;
        cmd.meta.row   = phase_r_reg ? 3'(i_reg) : 3'(k_reg);
        cmd.meta.col   = 2'(j_reg);
        cmd.meta.last  = phase_r_reg && i_end && j_end;
        cmd.meta.zero  = phase_r_reg && (i_reg > j_reg);
        v_wr_addr      = (state_reg == S_LOAD) ? vaddr(vi_reg, ki_reg) : vaddr(i_reg, k_reg);
        v_rd_addr_a    = (state_reg == S_OUT_RD) ? vaddr(j_reg, k_reg) : vaddr(i_reg, k_reg);
        v_rd_addr_b    = (state_reg == S_DOT_RD || state_reg == S_UPD_RD) ?
                         vaddr(j_reg, k_reg) : v_rd_addr_a;
        r_addr         = (state_reg == S_R_WR) ? raddr(j_reg, i_reg) :
                         (state_reg == S_DIAG) ? raddr(i_reg, i_reg) : raddr(i_reg, j_reg);
        col_sel        = (state_reg == S_DIAG) ? i_reg : j_reg;

        if (cfg_wr_en)
        begin
            vi_next = '0;
            ki_next = '0;
            if (cfg_index == CFG_VECTOR_LENGTH)
            begin
                len_cfg_next = cfg_data;
            end
            else
            begin
                cnt_cfg_next = cfg_data[2:0];
            end
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LOAD_IN;
                    if (ki_reg == len_last)
                    begin
                        ki_next = '0;
                        if (vi_reg == cnt_last)
                        begin
                            vi_next    = '0;
                            i_next     = '0;
                            state_next = S_INIT;
                        end
                        else
                        begin
                            vi_next = vi_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        ki_next = ki_reg + KW'(1);
                    end
                end
            end
            S_INIT:
            begin
                cmd.op     = OP_FLAG_CLR;
                state_next = S_VEC;
            end
            S_VEC:
            begin
                j_next     = '0;
                state_next = (i_reg == '0) ? S_NORM_BEGIN : S_DOT_BEGIN;
            end
            S_DOT_BEGIN:
            begin
                cmd.op     = OP_ACC_CLR;
                k_next     = '0;
                state_next = S_DOT_RD;
            end
            S_DOT_RD:
            begin
                cmd.op     = OP_READ;
                state_next = S_DOT_MUL;
            end
            S_DOT_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_DOT_ACC;
            end
            S_DOT_ACC:
            begin
                cmd.op = OP_ACC_DOT;
                if (k_end)
                begin
                    state_next = S_R_WR;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_DOT_RD;
                end
            end
            S_R_WR:
            begin
                cmd.op     = OP_R_WR_OFF;
                k_next     = '0;
                state_next = S_UPD_RD;
            end
            S_UPD_RD:
            begin
                cmd.op     = OP_READ;
                state_next = S_UPD_MUL;
            end
            S_UPD_MUL:
            begin
                cmd.op     = OP_MUL_UPD;
                state_next = S_UPD_WR;
            end
            S_UPD_WR:
            begin
                cmd.op = OP_WR_UPD;
                if (k_end)
                begin
                    if (j_reg + CW'(1) == i_reg)
                    begin
                        state_next = S_NORM_BEGIN;
                    end
                    else
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = S_DOT_BEGIN;
                    end
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_UPD_RD;
                end
            end
            S_NORM_BEGIN:
            begin
                cmd.op     = OP_ACC_CLR;
                k_next     = '0;
                state_next = S_SQ_RD;
            end
            S_SQ_RD:
            begin
                cmd.op     = OP_READ;
                state_next = S_SQ_MUL;
            end
            S_SQ_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                cmd.op = OP_ACC_SQ;
                if (k_end)
                begin
                    state_next = S_SQRT_GO;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_SQ_RD;
                end
            end
            S_SQRT_GO:
            begin
                cmd.op     = OP_SQRT_START;
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (!status.sqrt_busy)
                begin
                    state_next = S_DIAG;
                end
            end
            S_DIAG:
            begin
                cmd.op = OP_R_WR_DIAG;
                k_next = '0;
                state_next = status.s_zero ? S_VEC_END : S_Q_RD;
            end
            S_Q_RD:
            begin
                cmd.op     = OP_READ;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.op     = OP_DIV_START;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_Q_WR;
                end
            end
            S_Q_WR:
            begin
                cmd.op = OP_WR_Q;
                if (k_end)
                begin
                    state_next = S_VEC_END;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_Q_RD;
                end
            end
            S_VEC_END:
            begin
                if (i_end)
                begin
                    k_next       = '0;
                    j_next       = '0;
                    phase_r_next = 1'b0;
                    state_next   = S_OUT_RD;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_VEC;
                end
            end
            S_OUT_RD:
            begin
                cmd.op     = OP_READ;
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                cmd.op         = OP_OUT_LOAD;
                out_valid_next = 1'b1;
                state_next     = S_OUT_HOLD;
            end
            S_OUT_HOLD:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_OUT_RD;
                    if (j_end)
                    begin
                        j_next = '0;
                        if (!phase_r_reg)
                        begin
                            if (k_end)
                            begin
                                phase_r_next = 1'b1;
                                i_next       = '0;
                            end
                            else
                            begin
                                k_next = k_reg + KW'(1);
                            end
                        end
                        else if (i_end)
                        begin
                            state_next = S_LOAD;
                        end
                        else
                        begin
                            i_next = i_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            vi_reg        <= '0;
            ki_reg        <= '0;
            phase_r_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            len_cfg_reg   <= 4'd8;
            cnt_cfg_reg   <= 3'd4;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            vi_reg        <= vi_next;
            ki_reg        <= ki_next;
            phase_r_reg   <= phase_r_next;
            out_valid_reg <= out_valid_next;
            len_cfg_reg   <= len_cfg_next;
            cnt_cfg_reg   <= cnt_cfg_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result word is pending");

    a_proj_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOT_RD || state_reg == S_UPD_RD) |-> (j_reg < i_reg))
        else $error("projection onto a vector that is not earlier");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOT_RD || state_reg == S_SQ_RD || state_reg == S_Q_RD)
        |-> (k_reg <= len_last))
        else $error("element index past vector length");

    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT_LD))
        else $error("result word raised outside output load");

    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (!status.sqrt_busy && !status.div_busy))
        else $error("arithmetic unit busy while loading");

endmodule

`default_nettype wire

// ----- rtl/core/mgs_qr_decomposition.sv -----
// ----------------------------------------------------------------------------
// mgs_qr_decomposition
// Modified Gram-Schmidt QR of up to MAX_COUNT vectors of up to MAX_LENGTH
// Q16.16 elements; emits Q row by row, then R row by row.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  cfg     | cfg_wr_en              | cfg_index, cfg_data
//  in      | in_valid / in_ready    | element
//  out     | out_valid / out_ready  | value, is_r_entry, row_index, col_index,
//          |                        | degenerate, last_result
//
//  Loading takes one element word per cycle; in_ready is low from the last
//  element of a set until its last result word is taken.
//  Per vector i: a projection onto each earlier vector, then the norm and
//  square root (32 steps), then a divide for each element.
//  Output: each word is read, loaded and held until out_ready takes it.
//  Reset loads vector_length 8 and vector_count 4; stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module mgs_qr_decomposition #(
    parameter int MAX_LENGTH = 8,
    parameter int MAX_COUNT  = 4
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic                             cfg_index,
    input  wire logic [mgsqr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [31:0]               element,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [31:0]                    value,
    output logic                                  is_r_entry,
    output logic [2:0]                            row_index,
    output logic [1:0]                            col_index,
    output logic                                  degenerate,
    output logic                                  last_result
);

    import mgsqr_pkg::*;

    localparam int AW  = (MAX_LENGTH * MAX_COUNT > 1) ? $clog2(MAX_LENGTH * MAX_COUNT) : 1;
    localparam int RAW = (MAX_COUNT * MAX_COUNT > 1) ? $clog2(MAX_COUNT * MAX_COUNT) : 1;
    localparam int CW  = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;

    dp_cmd_t        cmd;
    dp_status_t     status;
    logic [AW-1:0]  v_wr_addr;
    logic [AW-1:0]  v_rd_addr_a;
    logic [AW-1:0]  v_rd_addr_b;
    logic [RAW-1:0] r_addr;
    logic [CW-1:0]  col_sel;

    mgsqr_ctrl #(
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_COUNT  (MAX_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .cmd         (cmd),
        .v_wr_addr   (v_wr_addr),
        .v_rd_addr_a (v_rd_addr_a),
        .v_rd_addr_b (v_rd_addr_b),
        .r_addr      (r_addr),
        .col_sel     (col_sel)
    );

    mgsqr_datapath #(
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_COUNT  (MAX_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .v_wr_addr   (v_wr_addr),
        .v_rd_addr_a (v_rd_addr_a),
        .v_rd_addr_b (v_rd_addr_b),
        .r_addr      (r_addr),
        .col_sel     (col_sel),
        .element     (element),
        .status      (status),
        .value       (value),
        .is_r_entry  (is_r_entry),
        .row_index   (row_index),
        .col_index   (col_index),
        .degenerate  (degenerate),
        .last_result (last_result)
    );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Streams Q16.16 vector sets into the Gram-Schmidt QR block under random
// bursts and output stalls, predicts every Q and R word of each set with a
// bit-exact fixed-point model of the block, and checks the words in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mgsqr_pkg::*;

    localparam int LMAX = 8;
    localparam int CMAX = 4;

    typedef struct packed {
        logic signed [31:0] value;
        logic               is_r;
        logic [2:0]         row;
        logic [1:0]         col;
        logic               degen;
        logic               last;
    } qr_word_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] element;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] value;
    logic is_r_entry;
    logic [2:0] row_index;
    logic [1:0] col_index;
    logic degenerate;
    logic last_result;

    mgs_qr_decomposition DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .element(element),
        .out_valid(out_valid), .out_ready(out_ready),
        .value(value), .is_r_entry(is_r_entry), .row_index(row_index),
        .col_index(col_index), .degenerate(degenerate), .last_result(last_result)
    );

    logic signed [31:0] pending_elements[$];
    qr_word_t expected_words[$];

    logic signed [31:0] vec_mem[CMAX*LMAX];
    logic signed [31:0] r_mem[CMAX*CMAX];
    int unsigned loaded;
    logic [3:0] len_reg;
    logic [2:0] cnt_reg;
    logic [3:0] zero_flags;
    logic in_taken;

    int errors;
    int mismatches;
    longint cycles;
    int burst_left;
    int gap_left;
    int stall_phase;
    int stall_len;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int eff_len();
        if (len_reg == 0)
        begin
            return 1;
        end
        return (len_reg > LMAX) ? LMAX : len_reg;
    endfunction

    function automatic int eff_cnt();
        if (cnt_reg == 0)
        begin
            return 1;
        end
        return (cnt_reg > CMAX) ? CMAX : cnt_reg;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] x);
        if (x > 128'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (x < -128'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [127:0] round16(input logic signed [127:0] x);
        return (x + 128'sd32768) >>> 16;
    endfunction

    function automatic logic [63:0] sqrt_floor(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res = 0;
        rem = n;
        bitv = 64'd1 << 62;
        while (bitv > rem)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    task automatic orthonormalize(input int len, input int cnt);
        logic signed [127:0] acc;
        logic signed [31:0] coef;
        logic [64:0] ssum;
        logic [63:0] sq;
        logic [63:0] nrm;
        logic [63:0] mag;
        logic [63:0] qv;
        logic signed [63:0] vk;
        for (int a = 0; a < CMAX*CMAX; a++)
        begin
            r_mem[a] = 0;
        end
        zero_flags = 0;
        for (int i = 0; i < cnt; i++)
        begin
            for (int j = 0; j < i; j++)
            begin
                acc = 0;
                for (int k = 0; k < len; k++)
                begin
                    acc += 128'(vec_mem[i*LMAX+k]) * 128'(vec_mem[j*LMAX+k]);
                end
                coef = clamp32(round16(acc));
                for (int k = 0; k < len; k++)
                begin
                    vec_mem[i*LMAX+k] = clamp32(128'(vec_mem[i*LMAX+k])
                        - round16(128'(coef) * 128'(vec_mem[j*LMAX+k])));
                end
                r_mem[j*CMAX+i] = coef;
            end
            ssum = 0;
            for (int k = 0; k < len; k++)
            begin
                vk = vec_mem[i*LMAX+k];
                sq = vk * vk;
                ssum = ssum + sq;
                if (ssum[64])
                begin
                    ssum = {1'b0, 64'hffffffffffffffff};
                end
            end
            if (ssum == 0)
            begin
                zero_flags[i] = 1'b1;
            end
            else
            begin
                nrm = sqrt_floor(ssum[63:0]);
                r_mem[i*CMAX+i] = (nrm > 64'h7fffffff) ? 32'sh7fffffff : nrm[31:0];
                for (int k = 0; k < len; k++)
                begin
                    vk = vec_mem[i*LMAX+k];
                    mag = (vk < 0) ? -vk : vk;
                    qv = (mag * 64'd65536 + nrm / 2) / nrm;
                    vec_mem[i*LMAX+k] = (vk < 0) ? -qv[31:0] : qv[31:0];
                end
            end
        end
    endtask

    task automatic predict_element(input logic signed [31:0] x);
        int len;
        int cnt;
        qr_word_t w;
        len = eff_len();
        cnt = eff_cnt();
        if (loaded >= len*cnt)
        begin
            loaded = 0;
        end
        vec_mem[(loaded/len)*LMAX + loaded%len] = x;
        loaded++;
        if (loaded < len*cnt)
        begin
            return;
        end
        loaded = 0;
        orthonormalize(len, cnt);
        for (int a = 0; a < len; a++)
        begin
            for (int b = 0; b < cnt; b++)
            begin
                w = '{vec_mem[b*LMAX+a], 1'b0, a[2:0], b[1:0], zero_flags[b], 1'b0};
                expected_words.push_back(w);
            end
        end
        for (int a = 0; a < cnt; a++)
        begin
            for (int b = 0; b < cnt; b++)
            begin
                w = '{r_mem[a*CMAX+b], 1'b1, a[2:0], b[1:0], zero_flags[b],
                      (a == cnt-1 && b == cnt-1)};
                expected_words.push_back(w);
            end
        end
    endtask

    function automatic logic signed [31:0] rand_element(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 131071)) - 32'sd65536;
            2: return 32'sh7fffffff;
            3: return 32'sh80000000;
            4: return 0;
            default: return $signed($urandom_range(0, 33554431)) - 32'sd16777216;
        endcase
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_elements.size() > 0)
                begin
                    in_valid <= 1'b1;
                    element <= pending_elements.pop_front();
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            stall_phase++;
            if (stall_phase >= stall_len)
            begin
                stall_phase = 0;
                stall_len = $urandom_range(1, 12);
            end
            out_ready <= (stall_len > 8) ? 1'b1 : (stall_phase < stall_len / 2 + 1);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        qr_word_t got;
        qr_word_t want;
        cycles++;
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
        begin
            predict_element(element);
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = '{value, is_r_entry, row_index, col_index, degenerate, last_result};
            if (expected_words.size() == 0)
            begin
                errors++;
                if (mismatches < 10)
                begin
                    $display("unexpected word %h", got);
                end
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (mismatches < 10)
                    begin
                        $display("mismatch: expected val=%h r=%b row=%0d col=%0d dg=%b last=%b",
                                 want.value, want.is_r, want.row, want.col, want.degen,
                                 want.last);
                        $display("          actual   val=%h r=%b row=%0d col=%0d dg=%b last=%b",
                                 got.value, got.is_r, got.row, got.col, got.degen, got.last);
                    end
                    mismatches++;
                end
            end
        end
        if (cycles > 2000000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_elements.size() > 0 || in_valid || expected_words.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_VECTOR_LENGTH)
        begin
            len_reg = d;
        end
        else
        begin
            cnt_reg = d[2:0];
        end
        loaded = 0;
    endtask

    task automatic queue_sets(input int nsets, input int mode);
        int total;
        total = eff_len() * eff_cnt();
        for (int s = 0; s < nsets; s++)
        begin
            for (int e = 0; e < total; e++)
            begin
                pending_elements.push_back(rand_element(mode < 0 ? $urandom_range(0, 6)
                                                                 : mode));
            end
        end
    endtask

    initial
    begin
        logic signed [31:0] b;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_VECTOR_LENGTH;
        cfg_data = 0;
        in_valid = 1'b0;
        in_taken = 1'b0;
        element = 0;
        out_ready = 1'b0;
        len_reg = 4'd8;
        cnt_reg = 3'd4;
        loaded = 0;
        zero_flags = 0;
        errors = 0;
        mismatches = 0;
        cycles = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        stall_len = 4;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: small and full-size sets covering extremes, zero vectors, dependent vectors
        write_reg(CFG_VECTOR_LENGTH, 4'd2);
        write_reg(CFG_VECTOR_COUNT, 3'd2);
        pending_elements.push_back(32'sh7fffffff);
        pending_elements.push_back(32'sh80000000);
        pending_elements.push_back(0);
        pending_elements.push_back(0);
        pending_elements.push_back(32'sh00010000);
        pending_elements.push_back(32'sh00010000);
        pending_elements.push_back(32'sh00020000);
        pending_elements.push_back(32'sh00020000);
        wait_drained();
        write_reg(CFG_VECTOR_LENGTH, 4'd0);
        write_reg(CFG_VECTOR_COUNT, 3'd0);
        pending_elements.push_back(32'shffffffff);
        pending_elements.push_back(0);
        wait_drained();
        write_reg(CFG_VECTOR_LENGTH, 4'd15);
        write_reg(CFG_VECTOR_COUNT, 3'd7);
        for (int k = 0; k < 32; k++)
        begin
            b = (k % 2) ? 32'sh80000000 : 32'sh7fffffff;
            pending_elements.push_back((k < 8) ? 32'sh0 : b);
        end
        wait_drained();

        // random: sweep settings, mostly small sets
        for (int ph = 0; ph < 14; ph++)
        begin
            write_reg(CFG_VECTOR_LENGTH, (ph == 13) ? 4'd8 : 4'($urandom_range(0, 15)));
            write_reg(CFG_VECTOR_COUNT, (ph == 13) ? 3'd4 : 3'($urandom_range(0, 7)));
            // drop a partial set on purpose now and then
            if (ph % 4 == 1 && eff_len() * eff_cnt() > 1)
            begin
                pending_elements.push_back($urandom);
                wait_drained();
                write_reg(CFG_VECTOR_COUNT, cnt_reg);
            end
            queue_sets((eff_len() * eff_cnt() > 12) ? 1 : 3, -1);
            wait_drained();
        end

        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- mgs_qr_decomposition.f -----
rtl/core/mgsqr_pkg.sv
rtl/core/mgsqr_ram.sv
rtl/core/mgsqr_datapath.sv
rtl/core/mgsqr_ctrl.sv
rtl/core/mgs_qr_decomposition.sv
bench/tb_top.sv
